### rtl/jgda_pkg.sv
// ----------------------------------------------------------------------------
// jgda_pkg
// Shared widths, word layout and calendar helpers for the day advance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jgda_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  // input word layout
  localparam int unsigned InYearLo  = 0;
  localparam int unsigned InMonthLo = InYearLo + YearW;
  localparam int unsigned InDayLo   = InMonthLo + MonthW;
  localparam int unsigned InBits    = InDayLo + DayW;
  localparam int unsigned InDataW   = ((InBits + 7) / 8) * 8;

  // output word layout
  localparam int unsigned OutYearLo  = 0;
  localparam int unsigned OutMonthLo = OutYearLo + YearW;
  localparam int unsigned OutDayLo   = OutMonthLo + MonthW;
  localparam int unsigned OutLeapBit = OutDayLo + DayW;
  localparam int unsigned OutBits    = OutLeapBit + 1;
  localparam int unsigned OutDataW   = ((OutBits + 7) / 8) * 8;

  typedef logic signed [YearW-1:0] year_t;
  typedef logic [MonthW-1:0]       month_t;
  typedef logic [DayW-1:0]         day_t;

  typedef enum logic {
    FUNC_ADVANCE = 1'b0,
    FUNC_LOAD    = 1'b1
  } func_e;

  localparam year_t  ResetYear  = -16'sd4713;
  localparam month_t ResetMonth = 4'd1;
  localparam day_t   ResetDay   = 5'd1;

  localparam year_t  LastYear      = 16'sd32767;
  localparam year_t  ReformYear    = 16'sd1582;
  localparam month_t ReformMonth   = 4'd10;
  localparam day_t   ReformLastDay = 5'd4;
  localparam day_t   ReformNextDay = 5'd15;
  localparam month_t LastMonth     = 4'd12;
  localparam month_t February      = 4'd2;

  // year divisible by 25, for 0 <= y < 32768
  function automatic logic div25(input logic [YearW-2:0] y);
    logic [9:0] s1;
    logic [7:0] s2;
    logic       hit;
    s1  = 10'(y[14:8]) * 10'd6 + 10'(y[7:0]);
    s2  = 8'(s1[9:5]) * 8'd7 + 8'(s1[4:0]);
    hit = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (s2 == 8'(i * 25)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_leap(input year_t y);
    logic d4;
    logic d16;
    logic d25;
    d4  = (y[1:0] == 2'b00);
    d16 = (y[3:0] == 4'b0000);
    d25 = div25(y[YearW-2:0]);
    if (y[YearW-1]) begin
      return (y[1:0] == 2'b11);
    end else if (y >= ReformYear) begin
      return (d16 && d25) || (d4 && !d25);
    end else begin
      return d4;
    end
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    unique case (m) inside
      February:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/julian_gregorian_day_advance.sv
// ----------------------------------------------------------------------------
// julian_gregorian_day_advance
// Julian/Gregorian calendar date register, one day step or load per word.
// ----------------------------------------------------------------------------
// the result word is valid in the cycle after the input word is accepted
// throughput: one word per cycle while the output is not stalled, set by the single date register stage
// the date register doubles as the output register and holds while stalled
// reset: date -4713-01-01 (leap), no output word pending
`timescale 1ns / 1ps
`default_nettype none

module julian_gregorian_day_advance (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  // load_year, load_month, load_day, zero pad
  input  wire logic [jgda_pkg::InDataW-1:0] s_tdata_i,
  // func
  input  wire logic                         s_tuser_i,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  // year_out, month_out, day_out, leap_out, zero pad
  output logic [jgda_pkg::OutDataW-1:0]     m_tdata_o
);

  jgda_pkg::year_t  year_q, year_d;
  jgda_pkg::month_t month_q, month_d;
  jgda_pkg::day_t   day_q, day_d;
  logic             leap_q, leap_d;
  logic             valid_q, valid_d;
  logic             accept;
  jgda_pkg::day_t   len;
  jgda_pkg::year_t  ld_year;
  jgda_pkg::month_t ld_month;
  jgda_pkg::day_t   ld_day;

  assign s_tready_o = !valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  assign ld_year  = s_tdata_i[jgda_pkg::InYearLo  +: jgda_pkg::YearW];
  assign ld_month = s_tdata_i[jgda_pkg::InMonthLo +: jgda_pkg::MonthW];
  assign ld_day   = s_tdata_i[jgda_pkg::InDayLo   +: jgda_pkg::DayW];

  assign len = jgda_pkg::month_len(month_q, leap_q);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    if (jgda_pkg::func_e'(s_tuser_i) == jgda_pkg::FUNC_LOAD) begin
      year_d  = ld_year;
      month_d = ld_month;
      day_d   = ld_day;
    end else if (year_q == jgda_pkg::ReformYear && month_q == jgda_pkg::ReformMonth &&
                 day_q == jgda_pkg::ReformLastDay) begin
      day_d = jgda_pkg::ReformNextDay;
    end else if (day_q >= len) begin
      if (month_q >= jgda_pkg::LastMonth) begin
        if (year_q != jgda_pkg::LastYear) begin
          year_d  = (year_q == -16'sd1) ? 16'sd1 : year_q + 16'sd1;
          month_d = 4'd1;
          day_d   = 5'd1;
        end
      end else begin
        month_d = month_q + 4'd1;
        day_d   = 5'd1;
      end
    end else begin
      day_d = day_q + 5'd1;
    end
    leap_d = jgda_pkg::is_leap(year_d);
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      year_q  <= jgda_pkg::ResetYear;
      month_q <= jgda_pkg::ResetMonth;
      day_q   <= jgda_pkg::ResetDay;
      leap_q  <= 1'b1;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
        leap_q  <= leap_d;
      end
    end
  end

  assign m_tvalid_o = valid_q;

  always_comb begin
    m_tdata_o = '0;
    m_tdata_o[jgda_pkg::OutYearLo  +: jgda_pkg::YearW]  = year_q;
    m_tdata_o[jgda_pkg::OutMonthLo +: jgda_pkg::MonthW] = month_q;
    m_tdata_o[jgda_pkg::OutDayLo   +: jgda_pkg::DayW]   = day_q;
    m_tdata_o[jgda_pkg::OutLeapBit]                     = leap_q;
  end

endmodule

`default_nettype wire

### rtl/jgda_checker.sv
// ----------------------------------------------------------------------------
// jgda_checker
// Port-level checks for the day advance block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jgda_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_tvalid_i,
  input wire logic                          s_tready_o,
  input wire logic [jgda_pkg::InDataW-1:0]  s_tdata_i,
  input wire logic                          s_tuser_i,
  input wire logic                          m_tvalid_o,
  input wire logic                          m_tready_i,
  input wire logic [jgda_pkg::OutDataW-1:0] m_tdata_o
);

  logic in_acc;
  assign in_acc = s_tvalid_i && s_tready_o;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result word changed while stalled");

  // input side is open whenever the result slot frees up
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (!m_tvalid_o || m_tready_i))
    else $error("input ready does not follow result slot");

  // a load shows the given date in the next word
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_tuser_i |=> m_tvalid_o &&
      m_tdata_o[jgda_pkg::OutDayLo-1:0] == $past(s_tdata_i[jgda_pkg::InDayLo-1:0]) &&
      m_tdata_o[jgda_pkg::OutLeapBit-1:jgda_pkg::OutDayLo] ==
        $past(s_tdata_i[jgda_pkg::InBits-1:jgda_pkg::InDayLo]))
    else $error("loaded date not shown");

  // an advance never leaves day zero
  a_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_tuser_i |=> m_tvalid_o &&
      m_tdata_o[jgda_pkg::OutLeapBit-1:jgda_pkg::OutDayLo] != '0)
    else $error("advance produced day zero");

endmodule

bind julian_gregorian_day_advance jgda_checker u_jgda_checker (.*);

`default_nettype wire

### tb/tb_julian_gregorian_day_advance.sv
// ----------------------------------------------------------------------------
// tb_julian_gregorian_day_advance
// Self-checking bench for the calendar day advance block. A scoreboard class
// keeps its own date register, predicts the date word that follows each
// accepted input word, and compares it field by field with the output
// stream. A directed part covers the reform gap, the year -1 to 1 step, the
// end of range, odd loaded values and leap rules. Random load-and-advance
// runs follow under four source and sink idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_julian_gregorian_day_advance;
  import jgda_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseWords = 450;

  typedef struct packed {
    year_t  year;
    month_t month;
    day_t   day;
    logic   leap;
  } date_word_t;

  class calendar_scoreboard;
    int             cur_year;
    int             cur_month;
    int             cur_day;
    date_word_t     pending_dates[$];
    int             errors;
    int             words_in;
    int             words_out;
    int             loads;

    function new();
      cur_year  = ResetYear;
      cur_month = ResetMonth;
      cur_day   = ResetDay;
      errors    = 0;
      words_in  = 0;
      words_out = 0;
      loads     = 0;
    endfunction

    static function bit leap_year(int y);
      if (y < 0) return ((-y - 1) % 4) == 0;
      if (y >= ReformYear) return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      return (y % 4) == 0;
    endfunction

    static function int month_days(int y, int m);
      case (m)
        February:      return leap_year(y) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_word(func_e f, year_t ly, month_t lm, day_t ld);
      date_word_t nxt;
      words_in++;
      if (f == FUNC_LOAD) begin
        loads++;
        cur_year  = ly;
        cur_month = lm;
        cur_day   = ld;
      end else if (cur_year == ReformYear && cur_month == ReformMonth &&
                   cur_day == ReformLastDay) begin
        cur_day = ReformNextDay;
      end else if (cur_day >= month_days(cur_year, cur_month)) begin
        if (cur_month >= LastMonth) begin
          if (cur_year != LastYear) begin
            cur_year  = (cur_year == -1) ? 1 : cur_year + 1;
            cur_month = 1;
            cur_day   = 1;
          end
        end else begin
          cur_month = cur_month + 1;
          cur_day   = 1;
        end
      end else begin
        cur_day = cur_day + 1;
      end
      nxt.year  = year_t'(cur_year);
      nxt.month = month_t'(cur_month);
      nxt.day   = day_t'(cur_day);
      nxt.leap  = leap_year(cur_year);
      pending_dates.push_back(nxt);
    endfunction

    task check_word(logic [OutDataW-1:0] data);
      date_word_t want;
      year_t      got_year;
      month_t     got_month;
      day_t       got_day;
      logic       got_leap;
      words_out++;
      got_year  = data[OutYearLo +: YearW];
      got_month = data[OutMonthLo +: MonthW];
      got_day   = data[OutDayLo +: DayW];
      got_leap  = data[OutLeapBit];
      if (pending_dates.size() == 0) begin
        report($sformatf("output word %0d with nothing pending", words_out));
      end else begin
        want = pending_dates.pop_front();
        if (got_year !== want.year)
          report($sformatf("word %0d year %0d, want %0d", words_out, got_year, want.year));
        if (got_month !== want.month)
          report($sformatf("word %0d month %0d, want %0d", words_out, got_month, want.month));
        if (got_day !== want.day)
          report($sformatf("word %0d day %0d, want %0d", words_out, got_day, want.day));
        if (got_leap !== want.leap)
          report($sformatf("word %0d leap %0b, want %0b", words_out, got_leap, want.leap));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  // load_year, load_month, load_day, zero pad
  logic [InDataW-1:0]  s_tdata_i = '0;
  // func
  logic                s_tuser_i = 1'b0;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  // year_out, month_out, day_out, leap_out, zero pad
  logic [OutDataW-1:0] m_tdata_o;

  calendar_scoreboard sb;
  int                 src_idle_pct = 0;
  int                 sink_stall_pct = 0;
  int                 cycles = 0;

  julian_gregorian_day_advance dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_julian_gregorian_day_advance: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_tready_i <= (int'($urandom_range(99)) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o)
        sb.note_word(func_e'(s_tuser_i), s_tdata_i[InYearLo +: YearW],
                     s_tdata_i[InMonthLo +: MonthW], s_tdata_i[InDayLo +: DayW]);
      if (m_tvalid_o && m_tready_i) sb.check_word(m_tdata_o);
    end
  end

  task automatic send_word(func_e f, year_t y, month_t m, day_t d);
    logic [InDataW-1:0] word;
    while (int'($urandom_range(99)) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    word = '0;
    word[InYearLo +: YearW]   = y;
    word[InMonthLo +: MonthW] = m;
    word[InDayLo +: DayW]     = d;
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= f;
    s_tdata_i  <= word;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  task automatic advance_words(int count);
    for (int i = 0; i < count; i++)
      send_word(FUNC_ADVANCE, year_t'($urandom), month_t'($urandom), day_t'($urandom));
  endtask

  task automatic load_and_step(int y, int m, int d);
    send_word(FUNC_LOAD, year_t'(y), month_t'(m), day_t'(d));
    advance_words(1);
  endtask

  initial begin
    int    sent;
    int    run;
    int    y;
    int    m;
    int    d;
    int    src_phase[4];
    int    sink_phase[4];
    sb = new();
    src_phase  = '{0, 52, 0, 16};
    sink_phase = '{0, 0, 52, 16};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    advance_words(1);
    load_and_step(1582, 10, 4);
    load_and_step(1582, 10, 5);
    load_and_step(-1, 12, 31);
    load_and_step(32767, 12, 31);
    load_and_step(32767, 15, 31);
    load_and_step(-32768, 12, 31);
    load_and_step(0, 2, 28);
    load_and_step(1900, 2, 28);
    load_and_step(2000, 2, 28);
    load_and_step(1500, 2, 28);
    load_and_step(2023, 0, 31);
    load_and_step(2023, 13, 31);
    load_and_step(-5, 7, 0);
    load_and_step(2023, 4, 31);
    load_and_step(-1, 15, 0);
    send_word(FUNC_LOAD, 16'h0000, 4'h0, 5'h00);
    send_word(FUNC_ADVANCE, 16'hffff, 4'hf, 5'h1f);
    send_word(FUNC_LOAD, 16'h7fff, 4'hf, 5'h1f);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_phase[p];
      sink_stall_pct = sink_phase[p];
      sent = 0;
      while (sent < PhaseWords) begin
        if ($urandom_range(3) == 0) begin
          y = int'(year_t'($urandom));
          m = $urandom_range(15);
          d = $urandom_range(31);
        end else begin
          case ($urandom_range(7))
            0:       y = -1;
            1:       y = LastYear;
            2:       y = ReformYear;
            3:       y = 0;
            4:       y = $urandom_range(1, 3000);
            5:       y = 100 * $urandom_range(1, 327);
            6:       y = -int'($urandom_range(1, 32767));
            default: y = $urandom_range(1, 32767);
          endcase
          m = ($urandom_range(2) == 0) ? int'(LastMonth) : $urandom_range(1, 12);
          d = calendar_scoreboard::month_days(y, m) - $urandom_range(0, 3);
          if (y == ReformYear && $urandom_range(1) == 1) begin
            m = ReformMonth;
            d = $urandom_range(1, 14);
          end
        end
        send_word(FUNC_LOAD, year_t'(y), month_t'(m), day_t'(d));
        run = ($urandom_range(9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 40);
        if (sent + run + 1 > PhaseWords) run = PhaseWords - sent - 1;
        advance_words(run);
        sent += run + 1;
      end
    end

    s_tvalid_i <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d input words (%0d loads) and %0d output words",
             sb.words_in, sb.loads, sb.words_out);
    $display("over four source/sink idling phases after the directed corners");
    if (sb.errors == 0) begin
      $display("tb_julian_gregorian_day_advance: clean");
    end else begin
      $display("tb_julian_gregorian_day_advance: errors");
    end
    $finish;
  end

endmodule

### julian_gregorian_day_advance.f
rtl/jgda_pkg.sv
rtl/julian_gregorian_day_advance.sv
rtl/jgda_checker.sv
tb/tb_julian_gregorian_day_advance.sv
